### hw/rtl/keyword_lexer_core_macros.svh
// Assertion macros for the keyword lexer checker.
`ifndef KEYWORD_LEXER_CORE_MACROS_SVH
`define KEYWORD_LEXER_CORE_MACROS_SVH

// Clocked assertion with asynchronous active-low reset disable.
`define KLEX_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion that a condition implies a consequence in the same cycle.
`define KLEX_ASSERT_IMP(label, clk, rstn, cond, cons, msg) \
    `KLEX_ASSERT(label, clk, rstn, (cond) |-> (cons), msg)

`endif

### hw/rtl/klex_pkg.sv
// Shared types, constants and keyword tables for the keyword lexer.
`timescale 1ns / 1ps
`default_nettype none

package klex_pkg;

    // Default parameter values
    localparam int MAX_WORD_LEN_DEF = 128;
    localparam int TABLE_DEPTH_DEF  = 128;

    // Keyword table geometry
    localparam int NUM_KW     = 9;
    localparam int KW_MAXLEN  = 10;
    localparam logic [8:0] ALL_KW = 9'h1FF;

    // Field widths
    localparam int CH_W    = 8;
    localparam int KIDX_W  = 4;
    localparam int LEN_W   = 7;
    localparam int SLOT_W  = 7;
    localparam int KIND_W  = 2;
    localparam int TDATA_W = 32;

    // Output tdata bit positions, lowest field first
    localparam int KIDX_LSB  = 0;
    localparam int LEN_LSB   = KIDX_LSB + KIDX_W;
    localparam int SEP_LSB   = LEN_LSB + LEN_W;
    localparam int TRUNC_BIT = SEP_LSB + CH_W;
    localparam int DROP_BIT  = TRUNC_BIT + 1;
    localparam int SLOT_LSB  = DROP_BIT + 1;
    localparam int USED_W    = SLOT_LSB + SLOT_W;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Token classes
    typedef enum logic [KIND_W-1:0] {
        KIND_RESERVED = 2'd0,
        KIND_IDENT    = 2'd1,
        KIND_SEP      = 2'd2
    } kind_t;

    // Separator characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_RBRC  = 8'h7D;

    // Keyword spellings, zero padded
    localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAXLEN] = '{
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"#", "i", "n", "c", "l", "u", "d", "e", 8'h00, 8'h00},
        '{"<", "s", "t", "d", "l", "i", "b", ".", "h", ">"},
        '{"<", "s", "t", "d", "d", "i", "o", ".", "h", ">"},
        '{"m", "a", "i", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"p", "r", "i", "n", "t", "f", 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd2, 4'd4, 4'd3, 4'd8, 4'd10, 4'd10, 4'd4, 4'd6, 4'd6
    };

    // Work item handed from front to back: an optional word token and an
    // optional separator token, in that order.
    typedef struct packed {
        logic               word_vld;
        kind_t              word_kind;
        logic [KIDX_W-1:0]  word_kidx;
        logic [LEN_W-1:0]   word_len;
        logic               word_trunc;
        logic               sep_vld;
        logic [CH_W-1:0]    sep_char;
    } job_t;

    // Queue status toward the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // True for the twelve splitting characters
    function automatic logic is_sep(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_NL, CH_SEMI, CH_COMMA, CH_DOT,
                         CH_LPAR, CH_RPAR, CH_LBRK, CH_RBRK, CH_LBRC, CH_RBRC};
    endfunction

    // True for separators that make a token of their own
    function automatic logic is_emitting_sep(input logic [7:0] c);
        return !(c inside {CH_SPACE, CH_TAB, CH_NL});
    endfunction

    // Character c sits at position pos of keyword k
    function automatic logic kw_hit(input int k, input logic [LEN_W-1:0] pos,
                                    input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        if (pos < {3'd0, KW_LEN[k]})
            hit = (KW_TEXT[k][pos[3:0]] == c);
        return hit;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/klex_queue.sv
// Two-entry job queue between the lexer front and back.
`timescale 1ns / 1ps
`default_nettype none

module klex_queue
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire klex_pkg::job_t    push_job,
    input  wire logic              pop,
    output klex_pkg::job_t         head_job,
    output klex_pkg::q_status_t    status
);

    localparam int PTR_W = $clog2(klex_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(klex_pkg::QUEUE_DEPTH + 1);

    klex_pkg::job_t   mem_reg [klex_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    // Gate pushes and pops by occupancy
    assign status.full  = (count_reg == CNT_W'(klex_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_job     = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(klex_pkg::QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(klex_pkg::QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the job
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

### hw/rtl/klex_front.sv
// Lexer front: accepts characters, tracks the pending word, classifies tokens.
`timescale 1ns / 1ps
`default_nettype none

module klex_front
#(
    parameter int MAX_WORD_LEN = klex_pkg::MAX_WORD_LEN_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [klex_pkg::CH_W-1:0] in_ch,
    input  wire logic                     in_end,
    input  wire klex_pkg::q_status_t      q_status,
    output logic                          push,
    output klex_pkg::job_t                push_job
);

    localparam int WORD_CAP = (MAX_WORD_LEN - 1 < 127) ? MAX_WORD_LEN - 1 : 127;

    logic [klex_pkg::LEN_W-1:0]  pend_len_reg, pend_len_next;
    logic [klex_pkg::NUM_KW-1:0] mask_reg, mask_next;
    logic                        ovf_reg, ovf_next;
    logic                        accept, sep_in, flush;
    klex_pkg::job_t              job;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign sep_in   = !in_end && klex_pkg::is_sep(in_ch);
    assign flush    = in_end || sep_in;

    // Classify the pending word and any separator token
    always_comb
    begin
        job            = '0;
        job.word_vld   = flush && (pend_len_reg != '0);
        job.word_kind  = klex_pkg::KIND_IDENT;
        job.word_len   = pend_len_reg;
        job.word_trunc = ovf_reg;
        for (int k = klex_pkg::NUM_KW - 1; k >= 0; k--)
        begin
            if (mask_reg[k] && ({3'd0, klex_pkg::KW_LEN[k]} == pend_len_reg))
            begin
                job.word_kind = klex_pkg::KIND_RESERVED;
                job.word_kidx = klex_pkg::KIDX_W'(k);
            end
        end
        job.sep_vld  = sep_in && klex_pkg::is_emitting_sep(in_ch);
        job.sep_char = job.sep_vld ? in_ch : '0;
    end

    assign push     = accept && (job.word_vld || job.sep_vld);
    assign push_job = job;

    // Update the pending word state
    always_comb
    begin
        pend_len_next = pend_len_reg;
        mask_next     = mask_reg;
        ovf_next      = ovf_reg;
        if (accept)
        begin
            if (flush)
            begin
                pend_len_next = '0;
                mask_next     = klex_pkg::ALL_KW;
                ovf_next      = 1'b0;
            end
            else if (pend_len_reg >= klex_pkg::LEN_W'(WORD_CAP))
            begin
                ovf_next  = 1'b1;
                mask_next = '0;
            end
            else
            begin
                for (int k = 0; k < klex_pkg::NUM_KW; k++)
                    mask_next[k] = mask_reg[k] && klex_pkg::kw_hit(k, pend_len_reg, in_ch);
                pend_len_next = pend_len_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_len_reg <= '0;
            mask_reg     <= klex_pkg::ALL_KW;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            pend_len_reg <= pend_len_next;
            mask_reg     <= mask_next;
            ovf_reg      <= ovf_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/klex_back.sv
// Lexer back: assigns table slots and emits token records one beat at a time.
`timescale 1ns / 1ps
`default_nettype none

module klex_back
#(
    parameter int TABLE_DEPTH = klex_pkg::TABLE_DEPTH_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire klex_pkg::job_t               head_job,
    input  wire klex_pkg::q_status_t          q_status,
    output logic                              pop,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [klex_pkg::TDATA_W-1:0]      out_data,
    output logic [klex_pkg::KIND_W-1:0]       out_kind,
    output logic                              out_last
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        phase_reg, phase_next;
    logic                        valid_reg, valid_next;
    logic [klex_pkg::TDATA_W-1:0] data_reg;
    logic [klex_pkg::KIND_W-1:0] kind_reg;
    logic                        last_reg;

    logic                        load, word_beat, rec_last, full_tbl;
    logic [CNT_W+klex_pkg::SLOT_W-1:0] count_ext;
    logic [klex_pkg::SLOT_W-1:0] slot;
    logic [klex_pkg::TDATA_W-1:0] rec_data;
    logic [klex_pkg::KIND_W-1:0] rec_kind;

    // Load a new beat when the output register is free or draining
    assign load      = !q_status.empty && (!valid_reg || out_ready);
    assign word_beat = !phase_reg && head_job.word_vld;
    assign rec_last  = !word_beat || !head_job.sep_vld;
    assign pop       = load && rec_last;

    // Claim a slot
    assign full_tbl  = (count_reg >= DEPTH_C);
    assign count_ext = {{klex_pkg::SLOT_W{1'b0}}, count_reg};
    assign slot      = full_tbl ? '0 : count_ext[klex_pkg::SLOT_W-1:0];

    // Build the record for this beat
    always_comb
    begin
        rec_data = '0;
        if (word_beat)
        begin
            rec_kind = head_job.word_kind;
            rec_data[klex_pkg::KIDX_LSB +: klex_pkg::KIDX_W] = head_job.word_kidx;
            rec_data[klex_pkg::LEN_LSB +: klex_pkg::LEN_W]   = head_job.word_len;
            rec_data[klex_pkg::TRUNC_BIT]                    = head_job.word_trunc;
        end
        else
        begin
            rec_kind = klex_pkg::KIND_SEP;
            rec_data[klex_pkg::LEN_LSB +: klex_pkg::LEN_W] = klex_pkg::LEN_W'(1);
            rec_data[klex_pkg::SEP_LSB +: klex_pkg::CH_W]  = head_job.sep_char;
        end
        rec_data[klex_pkg::DROP_BIT]                      = full_tbl;
        rec_data[klex_pkg::SLOT_LSB +: klex_pkg::SLOT_W]  = slot;
    end

    // Advance phase, table count and output valid
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        valid_next = valid_reg;
        if (valid_reg && out_ready)
            valid_next = 1'b0;
        if (load)
        begin
            valid_next = 1'b1;
            phase_next = !rec_last;
            if (!full_tbl)
                count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    // Hold the beat payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= rec_data;
            kind_reg <= rec_kind;
            last_reg <= rec_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_kind  = kind_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

### hw/rtl/keyword_lexer_core.sv
// Top level of the keyword lexer: front, job queue and back.
// Takes one character (or an end marker) per beat and returns token records.
// The input side accepts one beat every cycle while the two-entry job queue
// has room; a character that closes a word and is itself a token makes two
// records, which leave one after the other through the single output
// register, so the output port sets the sustained rate. A record passes
// through the job queue and the output register before m_axis_tvalid rises.
// Words keep min(MAX_WORD_LEN - 1, 127) characters; table slots run from zero to
// TABLE_DEPTH - 1, after which records are marked dropped with slot zero.
// End markers flush the pending word but keep the table count.
`timescale 1ns / 1ps
`default_nettype none

module keyword_lexer_core
#(
    parameter int MAX_WORD_LEN = klex_pkg::MAX_WORD_LEN_DEF,
    parameter int TABLE_DEPTH  = klex_pkg::TABLE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  wire logic        s_axis_tuser,   // [0] is_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [3:0] keyword_index, [10:4] word_length,
                                             // [18:11] sep_char, [19] truncated,
                                             // [20] dropped, [27:21] slot, [31:28] zero
    output logic [1:0]       m_axis_tuser,   // [1:0] kind
    output logic             m_axis_tlast    // last_of_run
);

    klex_pkg::q_status_t q_status;
    klex_pkg::job_t      push_job, head_job;
    logic                push, pop;

    klex_front #(
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_ch    (s_axis_tdata),
        .in_end   (s_axis_tuser),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    klex_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    klex_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_kind  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

### hw/rtl/klex_checker.sv
// Port-level checker for the keyword lexer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "keyword_lexer_core_macros.svh"

module klex_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    logic sep_beat, drop_beat;

    assign sep_beat  = m_axis_tvalid && (m_axis_tuser == klex_pkg::KIND_SEP);
    assign drop_beat = m_axis_tvalid && m_axis_tdata[klex_pkg::DROP_BIT];

    // Stalled beat holds
    `KLEX_ASSERT(a_out_hold, clk, rst_n,
        (m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)),
        "output beat changed while stalled")

    // Separator tokens close every run and are one character long
    `KLEX_ASSERT_IMP(a_sep_shape, clk, rst_n, sep_beat,
        m_axis_tlast
            && (m_axis_tdata[klex_pkg::LEN_LSB +: klex_pkg::LEN_W] == 7'd1)
            && !m_axis_tdata[klex_pkg::TRUNC_BIT],
        "separator record malformed")

    // Dropped tokens carry slot zero
    `KLEX_ASSERT_IMP(a_drop_slot, clk, rst_n, drop_beat,
        m_axis_tdata[klex_pkg::SLOT_LSB +: klex_pkg::SLOT_W] == 7'd0,
        "dropped record has nonzero slot")

    // Word tokens carry no separator byte and a nonzero length
    `KLEX_ASSERT_IMP(a_word_shape, clk, rst_n, m_axis_tvalid && !sep_beat,
        (m_axis_tdata[klex_pkg::SEP_LSB +: klex_pkg::CH_W] == 8'd0)
            && (m_axis_tdata[klex_pkg::LEN_LSB +: klex_pkg::LEN_W] != 7'd0),
        "word record malformed")

endmodule

bind keyword_lexer_core klex_checker u_klex_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

### test/tb.sv
// Self-checking stream testbench for the keyword lexer core.
`timescale 1ns / 1ps

module tb;

    localparam int MAX_WORD     = 128;
    localparam int TABLE_SIZE   = 128;
    localparam int WORD_CAP     = (MAX_WORD - 1 < 127) ? MAX_WORD - 1 : 127;
    localparam int RANDOM_ITEMS = 1800;
    localparam int IDLE_PCT     = 13;
    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_AT     = 150;
    localparam int STALL_CYCLES = 400;
    localparam int CALM_FROM    = 1200;
    localparam int CALM_TO      = 1800;

    // One character beat queued for the driver
    typedef struct {
        logic [7:0] ch;
        logic       is_end;
        bit         hold;
    } char_beat_t;

    // One token record as the block should return it
    typedef struct {
        klex_pkg::kind_t kind;
        logic [3:0]      kidx;
        logic [6:0]      len;
        logic [7:0]      sep;
        logic            trunc;
        logic            drop;
        logic [6:0]      slot;
        logic            last;
    } token_rec_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  in_ch = 8'h00;
    logic        in_end = 1'b0;
    logic        out_ready = 1'b0;
    logic        m_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    char_beat_t  char_feed[$];
    char_beat_t  next_beat;
    token_rec_t  token_q[$];
    token_rec_t  want;
    bit          hold_next = 1'b0;

    // Lexer state mirrored by the predictor
    int          pend_len = 0;
    logic [8:0]  kw_live = 9'h1FF;
    bit          word_cut = 1'b0;
    int          tokens_used = 0;

    int          cyc = 0;
    int          quiet = 0;
    int          recs_seen = 0;
    int          stall_left = 0;
    bit          stall_done = 1'b0;
    int          mismatches = 0;
    wire         calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

    keyword_lexer_core #(
        .MAX_WORD_LEN (MAX_WORD),
        .TABLE_DEPTH  (TABLE_SIZE)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (in_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (in_ch),
        .s_axis_tuser  (in_end),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (out_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 clk = ~clk;

    always @(posedge clk) cyc <= cyc + 1;

    function automatic bit splits(input logic [7:0] c);
        case (c)
            " ", "\t", "\n", ";", ",", ".", "(", ")", "[", "]", "{", "}": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic string kw_word(input int k);
        case (k)
            0: return "if";
            1: return "else";
            2: return "int";
            3: return "#include";
            4: return "<stdlib.h>";
            5: return "<stddio.h>";
            6: return "main";
            7: return "return";
            default: return "printf";
        endcase
    endfunction

    // Build a record and take the next table slot if any is left
    function automatic token_rec_t claim_slot(input klex_pkg::kind_t k,
                                              input logic [3:0] ki,
                                              input logic [6:0] len,
                                              input logic [7:0] sc,
                                              input logic tr);
        token_rec_t r;
        r.kind  = k;
        r.kidx  = ki;
        r.len   = len;
        r.sep   = sc;
        r.trunc = tr;
        r.last  = 1'b0;
        if (tokens_used < TABLE_SIZE)
        begin
            r.drop = 1'b0;
            r.slot = tokens_used[6:0];
            tokens_used++;
        end
        else
        begin
            r.drop = 1'b1;
            r.slot = '0;
        end
        return r;
    endfunction

    // Advance the lexer by one accepted beat and queue the records it makes
    function automatic void lex_step(input logic [7:0] c, input logic end_mark);
        token_rec_t recs[$];
        string      w;
        int         hit;
        if (end_mark || splits(c))
        begin
            if (pend_len > 0)
            begin
                hit = -1;
                for (int k = 0; k < 9; k++)
                begin
                    w = kw_word(k);
                    if (hit < 0 && kw_live[k] && w.len() == pend_len)
                        hit = k;
                end
                if (hit >= 0)
                    recs.push_back(claim_slot(klex_pkg::KIND_RESERVED, hit[3:0],
                                              pend_len[6:0], 8'h00, word_cut));
                else
                    recs.push_back(claim_slot(klex_pkg::KIND_IDENT, 4'd0,
                                              pend_len[6:0], 8'h00, word_cut));
            end
            pend_len = 0;
            kw_live  = '1;
            word_cut = 1'b0;
            if (!end_mark && c != " " && c != "\t" && c != "\n")
                recs.push_back(claim_slot(klex_pkg::KIND_SEP, 4'd0, 7'd1, c, 1'b0));
        end
        else if (pend_len >= WORD_CAP)
        begin
            // drop the character, the word can no longer be a keyword
            word_cut = 1'b1;
            kw_live  = '0;
        end
        else
        begin
            for (int k = 0; k < 9; k++)
            begin
                w = kw_word(k);
                if (!(pend_len < w.len() && w[pend_len] == c))
                    kw_live[k] = 1'b0;
            end
            pend_len++;
        end
        if (recs.size() > 0)
            recs[recs.size() - 1].last = 1'b1;
        foreach (recs[i])
            token_q.push_back(recs[i]);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    // Stimulus helpers
    function automatic void push_char(input logic [7:0] c);
        char_beat_t b;
        b.ch      = c;
        b.is_end  = 1'b0;
        b.hold    = hold_next;
        hold_next = 1'b0;
        char_feed.push_back(b);
    endfunction

    function automatic void push_end();
        char_beat_t b;
        b.ch      = 8'($urandom_range(0, 255));
        b.is_end  = 1'b1;
        b.hold    = hold_next;
        hold_next = 1'b0;
        char_feed.push_back(b);
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endfunction

    function automatic logic [7:0] word_byte();
        logic [7:0] c;
        string      alpha;
        alpha = "ifelsntcudmarp<>#h";
        if ($urandom_range(0, 1) == 0)
            return alpha[$urandom_range(0, alpha.len() - 1)];
        do
            c = 8'($urandom_range(0, 255));
        while (splits(c));
        return c;
    endfunction

    function automatic logic [7:0] sep_byte();
        string seps;
        seps = " \t\n;,.()[]{}";
        return seps[$urandom_range(0, seps.len() - 1)];
    endfunction

    // Sender: present queued beats, predict each one as it is accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_ch    <= 8'h00;
            in_end   <= 1'b0;
        end
        else
        begin
            if (in_valid && s_axis_tready)
                lex_step(in_ch, in_end);
            if (!in_valid || s_axis_tready)
            begin
                if (char_feed.size() > 0
                    && !(char_feed[0].hold && token_q.size() > 0)
                    && (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    next_beat = char_feed.pop_front();
                    in_valid <= 1'b1;
                    in_ch    <= next_beat.ch;
                    in_end   <= next_beat.is_end;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each record against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && out_ready)
            begin
                recs_seen <= recs_seen + 1;
                if (token_q.size() == 0)
                begin
                    $error("unexpected record: tdata %h tuser %0d tlast %0d",
                           m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    mismatches++;
                end
                else
                begin
                    want = token_q.pop_front();
                    check_field("kind", want.kind, m_axis_tuser);
                    check_field("keyword_index", want.kidx, m_axis_tdata[3:0]);
                    check_field("word_length", want.len, m_axis_tdata[10:4]);
                    check_field("sep_char", want.sep, m_axis_tdata[18:11]);
                    check_field("truncated", want.trunc, m_axis_tdata[19]);
                    check_field("dropped", want.drop, m_axis_tdata[20]);
                    check_field("slot", want.slot, m_axis_tdata[27:21]);
                    check_field("tdata padding", 0, m_axis_tdata[31:28]);
                    check_field("last_of_run", want.last, m_axis_tlast);
                end
            end
            // hold off once for a long stretch so the block backs up
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end
            else if (!stall_done && recs_seen == STALL_AT)
            begin
                stall_done <= 1'b1;
                stall_left <= STALL_CYCLES;
                out_ready  <= 1'b0;
            end
            else
            begin
                out_ready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
            end
        end
    end

    // Watchdog: count cycles with no beat moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && s_axis_tready) || (m_axis_tvalid && out_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int    base;
        int    pick;
        int    k;
        int    n;
        int    long_done;
        int    hold_at;
        string w;

        // directed: keyword, all separators, empty flushes, odd bytes
        push_text("if");
        push_char(";");
        push_end();
        push_text("else");
        push_char("{");
        push_char(8'h00);
        push_char(8'hFF);
        push_char("}");
        push_char("x");
        push_end();
        push_char(" ");
        push_char("\t");
        push_char("\n");
        push_text("()[],.");
        push_text("main");
        push_end();
        push_end();

        // random source text, mostly well-formed words and separators
        base      = char_feed.size();
        long_done = 0;
        hold_at   = 300;
        while (char_feed.size() < base + RANDOM_ITEMS)
        begin
            if (char_feed.size() >= base + hold_at)
            begin
                hold_next = 1'b1;
                hold_at += 400;
            end
            if (long_done < 3 && char_feed.size() >= base + 500 * (long_done + 1))
            begin
                // words around the buffer limit
                n = (long_done == 0) ? WORD_CAP
                  : (long_done == 1) ? WORD_CAP + 1 : WORD_CAP + 13;
                for (int i = 0; i < n; i++)
                    push_char(word_byte());
                push_char(sep_byte());
                long_done++;
                continue;
            end
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                push_text(kw_word($urandom_range(0, 8)));
            end
            else if (pick < 50)
            begin
                k = $urandom_range(0, 8);
                w = kw_word(k);
                case ($urandom_range(0, 2))
                    0: w[$urandom_range(0, w.len() - 1)] = word_byte();
                    1: w = w.substr(0, w.len() - 2);
                    default: w = {w, "s"};
                endcase
                push_text(w);
            end
            else if (pick < 75)
            begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                    push_char(word_byte());
            end
            else if (pick < 90)
            begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    push_char(8'($urandom_range(0, 255)));
            end
            else if (pick < 95)
            begin
                push_end();
            end
            else
            begin
                push_text(kw_word($urandom_range(0, 8)));
                push_end();
            end
            if ($urandom_range(0, 9) == 0)
                push_end();
            else
                push_char(sep_byte());
        end
        push_end();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // wait for the sender to run dry and every record to arrive
        while (char_feed.size() > 0 || in_valid || token_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && token_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/klex_pkg.sv
hw/rtl/klex_queue.sv
hw/rtl/klex_front.sv
hw/rtl/klex_back.sv
hw/rtl/keyword_lexer_core.sv
hw/rtl/klex_checker.sv
test/tb.sv
